@@ hw/rtl/pkmd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, register codes and control/status types of the cross-mean downsampler.
package pkmd_pkg;

    // Frame limits and pixel depth
    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;
    localparam int PIXEL_BITS  = 16;

    // Field and counter widths
    localparam int PIX_W      = 16;
    localparam int MEAN_W     = 16;
    localparam int DIM_W      = 13;
    localparam int ARM_W      = 11;
    localparam int OFFS_W     = ARM_W + 1;
    localparam int TILE_W     = 11;
    localparam int SUM_W      = 30;
    localparam int DIVISOR_W  = ARM_W + 2;
    localparam int STEP_W     = $clog2(SUM_W + 1);
    localparam int TILE_DEPTH = MAX_COLUMNS / 3;
    localparam int TILE_AW    = $clog2(TILE_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_LENGTH    = 2'd2;

    localparam logic [DIM_W-1:0] COLUMNS_RESET = 13'd640;
    localparam logic [DIM_W-1:0] ROWS_RESET    = 13'd480;
    localparam logic [ARM_W-1:0] ARM_RESET     = 11'd1;

    // Controller to datapath
    typedef struct packed {
        logic advance;
        logic update;
        logic div_start;
        logic load_out;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cfg_ok;
        logic needs_update;
        logic emit;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

@@ hw/rtl/pkmd_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module pkmd_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1365,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pkmd_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module pkmd_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pkmd_pkg::SUM_W-1:0]     i_dividend,
    input  logic [pkmd_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [pkmd_pkg::SUM_W-1:0]     o_quotient
);
    import pkmd_pkg::*;

    logic [STEP_W-1:0]    r_count;
    logic                 r_done;
    logic [DIVISOR_W-1:0] r_rem;
    logic [SUM_W-1:0]     r_dq;
    logic [DIVISOR_W-1:0] r_divisor;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W+1:0] trial;
    logic                 q_bit;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        shifted = {r_rem, r_dq[SUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_divisor};
        q_bit   = !trial[DIVISOR_W+1];
    end

    // Control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (i_start) begin
            r_count <= STEP_W'(SUM_W);
            r_done  <= 1'b0;
        end else if (r_count != '0) begin
            r_count <= r_count - 1'b1;
            r_done  <= (r_count == STEP_W'(1));
        end else begin
            r_done  <= 1'b0;
        end
    end

    // Datapath: remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_dq      <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_count != '0) begin
            r_rem <= q_bit ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            r_dq  <= {r_dq[SUM_W-2:0], q_bit};
        end
    end

    assign o_busy     = (r_count != '0);
    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

@@ hw/rtl/pkmd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences accept, store update, divide and result load.
module pkmd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pixel_valid,
    output logic                 o_pixel_ready,
    input  pkmd_pkg::t_dp_status i_status,
    output pkmd_pkg::t_ctrl_cmd  o_cmd
);
    import pkmd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIVIDE,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Commands from the current state
    always_comb begin
        accept          = i_pixel_valid && (r_state == S_IDLE);
        o_cmd.advance   = accept && i_status.cfg_ok;
        o_cmd.update    = (r_state == S_UPDATE);
        o_cmd.div_start = (r_state == S_UPDATE) && i_status.emit;
        o_cmd.load_out  = i_status.out_free &&
                          (((r_state == S_DIVIDE) && i_status.div_done) ||
                           (r_state == S_HOLD));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.advance && i_status.needs_update) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = i_status.emit ? S_DIVIDE : S_IDLE;
            end
            S_DIVIDE: begin
                if (i_status.div_done) begin
                    n_state = i_status.out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_pixel_ready = (r_state == S_IDLE);

    // The divider is never left running while new words are taken
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_status.div_busy)
        else $error("divider busy in idle state");

    // A result is never loaded over one that has not been taken
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("result register overwritten");

    // Divider completion only arrives while waiting for it
    a_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_DIVIDE))
        else $error("divider done outside divide state");

    // A started divide is seen running on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> i_status.div_busy)
        else $error("divider did not start");

endmodule

@@ hw/rtl/pkmd_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: settings, raster/tile counters, tile-sum store, divider and result register.
module pkmd_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [pkmd_pkg::PIX_W-1:0]      i_pixel,
    input  logic                            i_cfg_we,
    input  logic [pkmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pkmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  pkmd_pkg::t_ctrl_cmd             i_cmd,
    output pkmd_pkg::t_dp_status            o_status,
    input  logic                            i_result_ready,
    output logic                            o_result_valid,
    output logic [pkmd_pkg::MEAN_W-1:0]     o_mean_value,
    output logic [pkmd_pkg::TILE_W-1:0]     o_tile_column,
    output logic [pkmd_pkg::TILE_W-1:0]     o_tile_row,
    output logic                            o_frame_last
);
    import pkmd_pkg::*;

    // Settings
    logic [DIM_W-1:0] r_image_columns;
    logic [DIM_W-1:0] r_image_rows;
    logic [ARM_W-1:0] r_arm_length;

    // Raster and tile counters
    logic [DIM_W-1:0]  r_col_pos,    n_col_pos;
    logic [DIM_W-1:0]  r_row_pos,    n_row_pos;
    logic [OFFS_W-1:0] r_ox,         n_ox;
    logic [OFFS_W-1:0] r_oy,         n_oy;
    logic [TILE_W-1:0] r_tc,         n_tc;
    logic [TILE_W-1:0] r_tr,         n_tr;
    logic [DIM_W-1:0]  r_col_start,  n_col_start;
    logic [DIM_W-1:0]  r_row_start,  n_row_start;

    // Captured word
    logic [PIX_W-1:0]  r_pix;
    logic [TILE_W-1:0] r_cap_tc;
    logic [TILE_W-1:0] r_cap_tr;
    logic              r_start;
    logic              r_emit;
    logic              r_last;

    // Result register
    logic              r_result_valid;
    logic [MEAN_W-1:0] r_mean_value;
    logic [TILE_W-1:0] r_tile_column;
    logic [TILE_W-1:0] r_tile_row;
    logic              r_frame_last;

    logic [OFFS_W-1:0]    side;
    logic [DIVISOR_W-1:0] cross_count;
    logic                 cfg_ok;
    logic                 cfg_restart;
    logic                 in_tile;
    logic                 last_tile;
    logic                 on_vertical;
    logic                 on_horizontal;
    logic                 top_pixel;
    logic                 bottom_pixel;
    logic                 needs_update;
    logic                 col_wrap;
    logic                 row_wrap;
    logic [SUM_W-1:0]     sum_rd;
    logic [SUM_W-1:0]     sum_new;
    logic                 div_busy;
    logic                 div_done;
    logic [SUM_W-1:0]     quotient;
    logic                 out_free;

    // Tile geometry and checks on the settings
    always_comb begin
        side        = {r_arm_length, 1'b1};
        cross_count = {r_arm_length, 2'b01};
        cfg_ok      = (r_arm_length != '0) &&
                      (r_image_columns <= DIM_W'(MAX_COLUMNS)) &&
                      (r_image_rows <= DIM_W'(MAX_ROWS)) &&
                      ({1'b0, side} <= r_image_columns) &&
                      ({1'b0, side} <= r_image_rows);
        cfg_restart = i_cfg_we && ((i_cfg_index == CFG_IMAGE_COLUMNS) ||
                                   (i_cfg_index == CFG_IMAGE_ROWS) ||
                                   (i_cfg_index == CFG_ARM_LENGTH));
    end

    // Position of the current word within its tile
    always_comb begin
        in_tile = (({1'b0, r_col_start} + {2'b00, side}) <= {1'b0, r_image_columns}) &&
                  (({1'b0, r_row_start} + {2'b00, side}) <= {1'b0, r_image_rows});
        last_tile = (({2'b00, r_col_start} + {2'b00, side, 1'b0}) >
                     {2'b00, r_image_columns}) &&
                    (({2'b00, r_row_start} + {2'b00, side, 1'b0}) >
                     {2'b00, r_image_rows});
        on_vertical   = (r_ox == {1'b0, r_arm_length});
        on_horizontal = (r_oy == {1'b0, r_arm_length});
        top_pixel     = on_vertical && (r_oy == '0);
        bottom_pixel  = on_vertical && (r_oy == {r_arm_length, 1'b0});
        needs_update  = in_tile && (on_vertical || on_horizontal);
    end

    // Advance raster and tile counters
    always_comb begin
        n_col_pos   = r_col_pos;
        n_row_pos   = r_row_pos;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_tc        = r_tc;
        n_tr        = r_tr;
        n_col_start = r_col_start;
        n_row_start = r_row_start;
        col_wrap    = ({1'b0, r_col_pos} + 1'b1) >= {1'b0, r_image_columns};
        row_wrap    = ({1'b0, r_row_pos} + 1'b1) >= {1'b0, r_image_rows};
        if (cfg_restart) begin
            n_col_pos   = '0;
            n_row_pos   = '0;
            n_ox        = '0;
            n_oy        = '0;
            n_tc        = '0;
            n_tr        = '0;
            n_col_start = '0;
            n_row_start = '0;
        end else if (i_cmd.advance) begin
            n_col_pos = r_col_pos + 1'b1;
            if ((r_ox + 1'b1) == side) begin
                n_ox        = '0;
                n_tc        = r_tc + 1'b1;
                n_col_start = r_col_start + {1'b0, side};
            end else begin
                n_ox = r_ox + 1'b1;
            end
            if (col_wrap) begin
                n_col_pos   = '0;
                n_ox        = '0;
                n_tc        = '0;
                n_col_start = '0;
                n_row_pos   = r_row_pos + 1'b1;
                if ((r_oy + 1'b1) == side) begin
                    n_oy        = '0;
                    n_tr        = r_tr + 1'b1;
                    n_row_start = r_row_start + {1'b0, side};
                end else begin
                    n_oy = r_oy + 1'b1;
                end
                if (row_wrap) begin
                    n_row_pos   = '0;
                    n_oy        = '0;
                    n_tr        = '0;
                    n_row_start = '0;
                end
            end
        end
    end

    // Hold settings and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_columns <= COLUMNS_RESET;
            r_image_rows    <= ROWS_RESET;
            r_arm_length    <= ARM_RESET;
            r_col_pos       <= '0;
            r_row_pos       <= '0;
            r_ox            <= '0;
            r_oy            <= '0;
            r_tc            <= '0;
            r_tr            <= '0;
            r_col_start     <= '0;
            r_row_start     <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_IMAGE_COLUMNS)) begin
                r_image_columns <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_IMAGE_ROWS)) begin
                r_image_rows <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_ARM_LENGTH)) begin
                r_arm_length <= i_cfg_data[ARM_W-1:0];
            end
            r_col_pos   <= n_col_pos;
            r_row_pos   <= n_row_pos;
            r_ox        <= n_ox;
            r_oy        <= n_oy;
            r_tc        <= n_tc;
            r_tr        <= n_tr;
            r_col_start <= n_col_start;
            r_row_start <= n_row_start;
        end
    end

    // Capture the accepted word and its tile flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            r_pix    <= PIX_W'(i_pixel[PIXEL_BITS-1:0]);
            r_cap_tc <= r_tc;
            r_cap_tr <= r_tr;
            r_start  <= top_pixel;
            r_emit   <= bottom_pixel;
            r_last   <= last_tile;
        end
    end

    // Start a new sum at the top of the cross, otherwise accumulate
    always_comb begin
        sum_new = r_start ? SUM_W'(r_pix) : (sum_rd + SUM_W'(r_pix));
    end

    // Per-tile-column running sums
    pkmd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (TILE_DEPTH)
    ) u_tile_sums (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (TILE_AW'(r_cap_tc)),
        .i_wdata (sum_new),
        .i_re    (i_cmd.advance && needs_update),
        .i_raddr (TILE_AW'(r_tc)),
        .o_rdata (sum_rd)
    );

    // Mean of the cross pixels
    pkmd_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (sum_new),
        .i_divisor  (cross_count),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Result register: load on command, drop when taken
    assign out_free = !r_result_valid || i_result_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_result_valid <= 1'b1;
        end else if (i_result_ready) begin
            r_result_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_mean_value  <= quotient[MEAN_W-1:0];
            r_tile_column <= r_cap_tc;
            r_tile_row    <= r_cap_tr;
            r_frame_last  <= r_last;
        end
    end

    // Status to the controller
    always_comb begin
        o_status.cfg_ok       = cfg_ok;
        o_status.needs_update = needs_update;
        o_status.emit         = r_emit;
        o_status.div_busy     = div_busy;
        o_status.div_done     = div_done;
        o_status.out_free     = out_free;
    end

    assign o_result_valid = r_result_valid;
    assign o_mean_value   = r_mean_value;
    assign o_tile_column  = r_tile_column;
    assign o_tile_row     = r_tile_row;
    assign o_frame_last   = r_frame_last;

endmodule

@@ hw/rtl/plus_kernel_mean_downsampler.sv @@
`timescale 1ns / 1ps
// Top level: plus-shaped cross mean per tile, one result per whole tile.
// A word off the cross or outside whole tiles is accepted from idle alone; a cross word also
// takes a store update (store read, then write), and the bottom cross word then holds input
// for the 30-step divider. Its result is valid once the divider is done, plus any wait for
// the output register; a finished result waits there while the next words are accepted.
// Synchronous active-low reset restores settings and clears counters; the store keeps its data.
module plus_kernel_mean_downsampler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_pixel_valid,
    output logic                            o_pixel_ready,
    input  logic [pkmd_pkg::PIX_W-1:0]      i_pixel,
    input  logic                            i_cfg_we,
    input  logic [pkmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pkmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_result_valid,
    input  logic                            i_result_ready,
    output logic [pkmd_pkg::MEAN_W-1:0]     o_mean_value,
    output logic [pkmd_pkg::TILE_W-1:0]     o_tile_column,
    output logic [pkmd_pkg::TILE_W-1:0]     o_tile_row,
    output logic                            o_frame_last
);
    import pkmd_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Sequencer
    pkmd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // Counters, store, divider and result register
    pkmd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel        (i_pixel),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_result_ready (i_result_ready),
        .o_result_valid (o_result_valid),
        .o_mean_value   (o_mean_value),
        .o_tile_column  (o_tile_column),
        .o_tile_row     (o_tile_row),
        .o_frame_last   (o_frame_last)
    );

endmodule
